FILE: src/indexed_deque_engine_assert.svh
// ----------------------------------------------------------------------------
// Indexed deque engine assertion macros
// Shorthands for concurrent assertions sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_ENGINE_ASSERT_SVH
`define INDEXED_DEQUE_ENGINE_ASSERT_SVH

// Checked only while the block is out of reset.
`define IDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, during reset too.
`define IDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/ide_pkg.sv
// ----------------------------------------------------------------------------
// Indexed deque engine package
// Sizes, command and status codes, and the control bundles shared by the
// controller, the storage cells and the top level.
// ----------------------------------------------------------------------------
package ide_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic             up;    // open a slot at pos and load the new value there
    logic             down;  // move every element one cell toward the front
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;   // element count before the command
  } cell_ctl_t;

  // Result of one command as decided by the controller.
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             take_last;
    logic             take_first;
  } cmd_res_t;

endpackage

FILE: src/ide_cell.sv
// ----------------------------------------------------------------------------
// Indexed deque storage cell
// Holds one element and, on a command, keeps it, loads the new value, or
// takes the element of its left or right neighbor.
// ----------------------------------------------------------------------------
module ide_cell
  import ide_pkg::*;
(
  input  logic                clk_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  cell_ctl_t           ctl_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [DATA_W-1:0]   left_i,
  input  logic [DATA_W-1:0]   right_i,
  output logic [DATA_W-1:0]   data_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]  idx;

  assign idx = CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.up) begin
      if (idx == ctl_i.pos) begin
        data_d = value_i;
      end else if ((idx > ctl_i.pos) && (idx <= ctl_i.cnt)) begin
        data_d = left_i;
      end
    end else if (ctl_i.down) begin
      if ((idx + CNT_W'(1)) < ctl_i.cnt) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/ide_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed deque controller
// Holds the element count, checks each command against it and drives the
// shift controls of the cell row.
// ----------------------------------------------------------------------------
module ide_ctrl
  import ide_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [POS_W-1:0]   position_i,
  output cell_ctl_t          ctl_o,
  output cmd_res_t           res_o,
  output logic [CNT_W-1:0]   count_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             up, down;
  logic [CNT_W-1:0] pos;

  assign full = (count_q >= CNT_W'(CAPACITY));

  always_comb begin
    res_o.status     = ST_OK;
    res_o.take_last  = 1'b0;
    res_o.take_first = 1'b0;
    count_d          = count_q;
    up               = 1'b0;
    down             = 1'b0;
    pos              = count_q;
    case (kind_e'(kind_i))
      KIND_PUSH_BACK: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          up      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_PUSH_FRONT: begin
        pos = '0;
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          up      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP_BACK: begin
        if (count_q == '0) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.take_last = 1'b1;
          count_d         = count_q - CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (count_q == '0) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.take_first = 1'b1;
          down             = 1'b1;
          count_d          = count_q - CNT_W'(1);
        end
      end
      KIND_INSERT: begin
        pos = CNT_W'(position_i);
        // The range check comes before the full check.
        if (CNT_W'(position_i) > count_q) begin
          res_o.status = ST_RANGE;
        end else if (full) begin
          res_o.status = ST_FULL;
        end else begin
          up      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    res_o.count = count_d;
  end

  assign ctl_o.up    = up & accept_i;
  assign ctl_o.down  = down & accept_i;
  assign ctl_o.pos   = pos;
  assign ctl_o.cnt   = count_q;
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

endmodule

FILE: src/indexed_deque_engine.sv
// ----------------------------------------------------------------------------
// Indexed deque engine
// Ordered sequence of up to CAPACITY signed 32-bit values kept in a row of
// cells, with pushes and pops at both ends, insert at a position and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel and each gives exactly one result
//   transaction on the m_axis channel, in command order.
//   A command is executed in the cycle it is accepted: the whole cell row
//   shifts in parallel at that edge, so the result is offered in the next cycle.
//   Throughput is one command per cycle while the receiver takes results;
//   the limit is the cell row, updated in full as each command is accepted.
//   The result sits in an output register. While it waits to be taken,
//   s_axis_tready_o stays low, so a stalled receiver holds off new commands.
//   Reset clears the element count and the result valid flag; the cell
//   contents are left as they are and are never read before being written.
//   Pop on an empty sequence reports empty, push or insert on a full one
//   reports full, and an insert beyond the count reports out of range; in
//   those cases nothing changes.
// ----------------------------------------------------------------------------
module indexed_deque_engine
  import ide_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [2:0]  s_axis_tuser_i,  // kind[2:0]
  input  logic [39:0] s_axis_tdata_i,  // position[4:0], value[36:5], zero[39:37]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // status[1:0], removed_value[33:2],
                                       // count[38:34], zero[39]
);

  `include "indexed_deque_engine_assert.svh"

  logic                in_acc;
  logic [KIND_W-1:0]   kind;
  logic [POS_W-1:0]    position;
  logic [DATA_W-1:0]   value;
  cell_ctl_t           ctl;
  cmd_res_t            res;
  logic [CNT_W-1:0]    count_q;
  logic [DATA_W-1:0]   cell_v [CAPACITY];
  logic [DATA_W-1:0]   left_v [CAPACITY];
  logic [DATA_W-1:0]   right_v[CAPACITY];
  logic [IDX_W-1:0]    rd_idx;
  logic [DATA_W-1:0]   removed;
  logic                out_valid_q;
  logic [39:0]         out_data_q, out_data_d;
  logic                out_stalled;

  assign kind     = s_axis_tuser_i;
  assign position = s_axis_tdata_i[4:0];
  assign value    = s_axis_tdata_i[36:5];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  ide_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .kind_i     (kind),
    .position_i (position),
    .ctl_o      (ctl),
    .res_o      (res),
    .count_o    (count_q)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_v[g] = '0;
    end else begin : g_left
      assign left_v[g] = cell_v[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v[g] = '0;
    end else begin : g_right
      assign right_v[g] = cell_v[g+1];
    end

    ide_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .value_i (value),
      .left_i  (left_v[g]),
      .right_i (right_v[g]),
      .data_o  (cell_v[g])
    );
  end

  // Pop back reads the last element, pop front the first one.
  assign rd_idx = res.take_first ? '0 : IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    removed = '0;
    if (res.take_last || res.take_first) begin
      removed = cell_v[rd_idx];
    end
    out_data_d = {1'b0, res.count, removed, res.status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign out_stalled = m_axis_tvalid_o && !m_axis_tready_i;

  `IDE_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "element count above capacity")
  `IDE_ASSERT(a_count_hold, !in_acc |=> $stable(count_q), "count changed without a command")
  `IDE_ASSERT(a_stall_block, out_stalled |-> !s_axis_tready_o, "command taken in a stall")
  `IDE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

FILE: tb/tb_indexed_deque_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed deque engine testbench
// A short table of directed commands runs first: empty pops, range errors,
// extreme values, unused kinds, and a fill to capacity. Random command
// streams follow in four phases with different sender and receiver idling.
// Results are checked against a typed-in result or a local model of the sequence.
// ----------------------------------------------------------------------------
module tb_indexed_deque_engine;
  import ide_pkg::*;

  localparam int LIMIT_CYCLES     = 400000;
  localparam int RANDOM_PER_PHASE = 435;
  localparam int MAX_GAP          = 12;
  localparam int EXP_DEPTH        = 64;

  // Kinds 6 and 7 are not part of the package enum; the block ignores them.
  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   removed;
    logic [CNT_W-1:0]    count;
  } deque_result_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   value;   // incremented on each repetition
    int                  reps;
    bit                  typed;   // use the typed-in result below
    status_e             status;
    logic [DATA_W-1:0]   removed;
    logic [CNT_W-1:0]    count;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_POP_BACK,   5'd0,  32'h0000_0000, 1,  1'b1, ST_EMPTY, 32'h0, 5'd0},
    '{KIND_POP_FRONT,  5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_EMPTY, 32'h0, 5'd0},
    '{KIND_INSERT,     5'd1,  32'h1111_1111, 1,  1'b1, ST_RANGE, 32'h0, 5'd0},
    '{KIND_INSERT,     5'd31, 32'h2222_2222, 1,  1'b1, ST_RANGE, 32'h0, 5'd0},
    '{KIND_INSERT,     5'd0,  32'h7FFF_FFFF, 1,  1'b1, ST_OK,    32'h0, 5'd1},
    '{KIND_PUSH_FRONT, 5'd0,  32'h8000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd2},
    '{KIND_PUSH_BACK,  5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd3},
    '{KIND_INSERT,     5'd1,  32'hFFFF_FFFF, 1,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_INSERT,     5'd4,  32'h1234_5678, 1,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_POP_FRONT,  5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h8000_0000, 5'd4},
    '{KIND_POP_BACK,   5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h1234_5678, 5'd3},
    '{KIND_UNUSED_6,   5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd3},
    '{KIND_UNUSED_7,   5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,    32'h0, 5'd3},
    '{KIND_CLEAR,      5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd0},
    '{KIND_PUSH_BACK,  5'd0,  32'hA5A5_A5A0, 8,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_PUSH_FRONT, 5'd0,  32'h5A5A_5A50, 8,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_PUSH_BACK,  5'd0,  32'h7FFF_FFFF, 1,  1'b1, ST_FULL,  32'h0, 5'd16},
    '{KIND_PUSH_FRONT, 5'd0,  32'h8000_0000, 1,  1'b1, ST_FULL,  32'h0, 5'd16},
    '{KIND_INSERT,     5'd16, 32'h3333_3333, 1,  1'b1, ST_FULL,  32'h0, 5'd16},
    '{KIND_INSERT,     5'd17, 32'h4444_4444, 1,  1'b1, ST_RANGE, 32'h0, 5'd16},
    '{KIND_INSERT,     5'd8,  32'h5555_5555, 1,  1'b1, ST_FULL,  32'h0, 5'd16},
    '{KIND_POP_FRONT,  5'd0,  32'h0000_0000, 2,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_POP_BACK,   5'd0,  32'h0000_0000, 2,  1'b0, ST_OK,    32'h0, 5'd0},
    '{KIND_CLEAR,      5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,    32'h0, 5'd0}
  };

  int idle_by_phase  [4] = '{0, 47, 0, 38};
  int stall_by_phase [4] = '{0, 0, 47, 38};

  logic                clk_i;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [2:0]          s_tuser  = '0;
  logic [39:0]         s_tdata  = '0;
  logic                m_tready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [39:0]         m_axis_tdata_o;

  // Local copy of the sequence, updated as each command transaction is accepted.
  logic [DATA_W-1:0]   model_cells [CAPACITY];
  logic [CNT_W-1:0]    model_count = '0;

  // Expected results in order, kept in a ring with running write and read counts.
  deque_result_t       exp_ring [EXP_DEPTH];
  int                  exp_wr = 0;
  int                  exp_rd = 0;

  int                  n_errors   = 0;
  int                  n_commands = 0;
  int                  full_hits  = 0;
  int                  status_hist [4] = '{0, 0, 0, 0};
  int                  cycles     = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  growing    = 1'b1;
  int                  tide_left  = 0;

  indexed_deque_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Moves the elements from pos upward by one cell to free cell pos.
  function automatic void open_slot(input logic [CNT_W-1:0] pos);
    for (int i = int'(model_count); i > int'(pos); i--) begin
      model_cells[i] = model_cells[i-1];
    end
  endfunction

  function automatic deque_result_t deque_apply(input logic [KIND_W-1:0] k,
                                                input logic [POS_W-1:0]  p,
                                                input logic [DATA_W-1:0] v);
    deque_result_t res;
    bit            was_full;
    res.status = ST_OK;
    res.removed = '0;
    was_full = (model_count >= CAPACITY);
    case (k)
      KIND_PUSH_BACK: begin
        if (was_full) res.status = ST_FULL;
        else begin
          model_cells[model_count] = v;
          model_count++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (was_full) res.status = ST_FULL;
        else begin
          open_slot('0);
          model_cells[0] = v;
          model_count++;
        end
      end
      KIND_POP_BACK: begin
        if (model_count == 0) res.status = ST_EMPTY;
        else begin
          model_count--;
          res.removed = model_cells[model_count];
        end
      end
      KIND_POP_FRONT: begin
        if (model_count == 0) res.status = ST_EMPTY;
        else begin
          res.removed = model_cells[0];
          for (int i = 0; i + 1 < int'(model_count); i++) begin
            model_cells[i] = model_cells[i+1];
          end
          model_count--;
        end
      end
      KIND_INSERT: begin
        // The range check comes ahead of the full check.
        if (p > model_count) res.status = ST_RANGE;
        else if (was_full) res.status = ST_FULL;
        else begin
          open_slot(p);
          model_cells[p] = v;
          model_count++;
        end
      end
      KIND_CLEAR: model_count = '0;
      default: ;
    endcase
    if (model_count == CAPACITY && !was_full) full_hits++;
    res.count = model_count;
    return res;
  endfunction

  // One command transaction; tvalid stays high across back-to-back commands.
  task automatic send_command(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                              input logic [DATA_W-1:0] v, input bit typed,
                              input deque_result_t fixed);
    int            gap;
    deque_result_t model_res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {3'b000, v, p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_res = deque_apply(k, p, v);
    exp_ring[exp_wr % EXP_DEPTH] = typed ? fixed : model_res;
    exp_wr++;
    n_commands++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_wr != exp_rd);
  endtask

  // Random commands come in tides that mostly grow or mostly shrink the
  // sequence, so that both the full and the empty ends are reached often.
  task automatic random_command(output logic [KIND_W-1:0] k, output logic [POS_W-1:0] p,
                                output logic [DATA_W-1:0] v);
    int r;
    if (tide_left == 0) begin
      growing = ~growing;
      tide_left = $urandom_range(60, 20);
    end
    tide_left--;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 28)       k = KIND_PUSH_BACK;
      else if (r < 48)  k = KIND_PUSH_FRONT;
      else if (r < 73)  k = KIND_INSERT;
      else if (r < 85)  k = KIND_POP_BACK;
      else if (r < 97)  k = KIND_POP_FRONT;
      else if (r < 98)  k = KIND_CLEAR;
      else              k = r[0] ? KIND_UNUSED_7 : KIND_UNUSED_6;
    end else begin
      if (r < 15)       k = KIND_PUSH_BACK;
      else if (r < 25)  k = KIND_PUSH_FRONT;
      else if (r < 35)  k = KIND_INSERT;
      else if (r < 65)  k = KIND_POP_BACK;
      else if (r < 95)  k = KIND_POP_FRONT;
      else if (r < 97)  k = KIND_CLEAR;
      else              k = r[0] ? KIND_UNUSED_7 : KIND_UNUSED_6;
    end
    r = $urandom_range(99);
    if (k != KIND_INSERT || r < 20) p = POS_W'($urandom_range(31));
    else if (r < 40)                p = '0;
    else if (r < 55)                p = model_count;
    else                            p = POS_W'($urandom_range(int'(model_count)));
    case ($urandom_range(19))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h0000_0000;
      3:       v = 32'hFFFF_FFFF;
      default: v = $urandom();
    endcase
  endtask

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result transaction: tdata %h", m_axis_tdata_o);
        n_errors++;
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        status_hist[want.status]++;
        if (m_axis_tdata_o[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tdata_o[1:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[33:2] !== want.removed) begin
          $error("removed_value: expected %h, actual %h", want.removed,
                 m_axis_tdata_o[33:2]);
          n_errors++;
        end
        if (m_axis_tdata_o[38:34] !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, m_axis_tdata_o[38:34]);
          n_errors++;
        end
        if (m_axis_tdata_o[39] !== 1'b0) begin
          $error("pad bit: expected 0, actual %b", m_axis_tdata_o[39]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] v;
    deque_result_t     fixed;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    for (int row = 0; row < DIR_ROWS; row++) begin
      fixed.status  = dir_rows[row].status;
      fixed.removed = dir_rows[row].removed;
      fixed.count   = dir_rows[row].count;
      for (int rep = 0; rep < dir_rows[row].reps; rep++) begin
        send_command(dir_rows[row].kind, dir_rows[row].pos, dir_rows[row].value + rep,
                     dir_rows[row].typed, fixed);
      end
    end
    wait_for_results();

    // Each phase starts with the sender held off until all results are in.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct <= stall_by_phase[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_command(k, p, v);
        send_command(k, p, v, 1'b0, '0);
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk_i);
    if (exp_wr != exp_rd) begin
      $error("%0d expected results never arrived", exp_wr - exp_rd);
      n_errors++;
    end
    $display("Ran %0d commands over four idling phases; the sequence filled up %0d times.",
             n_commands, full_hits);
    $display("Statuses seen: ok %0d, out of range %0d, empty %0d, full %0d.",
             status_hist[ST_OK], status_hist[ST_RANGE], status_hist[ST_EMPTY],
             status_hist[ST_FULL]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
